// File: design/dstr_pkg.sv
// ----------------------------------------------------------------------------
// dstr_pkg
// Shared types and constants for the declaration specifier type resolver:
// token and result words, accumulated specifier state and type codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dstr_pkg;

    // Specifier token codes
    typedef enum logic [3:0] {
        SPEC_NONE     = 4'd0,
        SPEC_VOID     = 4'd1,
        SPEC_CHAR     = 4'd2,
        SPEC_INT      = 4'd3,
        SPEC_DOUBLE   = 4'd4,
        SPEC_FLOAT    = 4'd5,
        SPEC_TYPEDEF  = 4'd6,
        SPEC_COMPLEX  = 4'd7,
        SPEC_SHORT    = 4'd8,
        SPEC_LONG     = 4'd9,
        SPEC_SIGNED   = 4'd10,
        SPEC_UNSIGNED = 4'd11,
        SPEC_ENUM     = 4'd12,
        SPEC_STRUCT   = 4'd13,
        SPEC_UNION    = 4'd14,
        SPEC_SKIP     = 4'd15
    } dstr_spec_t;

    // Type codes
    localparam logic [4:0] T_ERROR      = 5'd0;
    localparam logic [4:0] T_PENDING    = 5'd1;
    localparam logic [4:0] T_VOID       = 5'd8;
    localparam logic [4:0] T_CHAR       = 5'd9;
    localparam logic [4:0] T_UCHAR      = 5'd10;
    localparam logic [4:0] T_SCHAR      = 5'd11;
    localparam logic [4:0] T_SHORT      = 5'd12;
    localparam logic [4:0] T_USHORT     = 5'd13;
    localparam logic [4:0] T_INT        = 5'd14;
    localparam logic [4:0] T_UINT       = 5'd15;
    localparam logic [4:0] T_LONG       = 5'd16;
    localparam logic [4:0] T_ULONG      = 5'd17;
    localparam logic [4:0] T_LLONG      = 5'd18;
    localparam logic [4:0] T_ULLONG     = 5'd19;
    localparam logic [4:0] T_FLOAT      = 5'd20;
    localparam logic [4:0] T_DOUBLE     = 5'd21;
    localparam logic [4:0] T_LDOUBLE    = 5'd22;
    localparam logic [4:0] T_FCOMPLEX   = 5'd23;
    localparam logic [4:0] T_DCOMPLEX   = 5'd24;
    localparam logic [4:0] T_LDCOMPLEX  = 5'd25;
    localparam logic [4:0] T_UNRESOLVED = 5'd26;

    localparam int RULE_COUNT = 15;

    // Input word: one specifier token
    typedef struct packed {
        logic [3:0] spec_code;
        logic [4:0] named_type_code;
        logic       last_token;
    } dstr_in_t;

    // Output word: one resolved declaration
    typedef struct packed {
        logic [4:0]            result_type;
        logic [RULE_COUNT-1:0] rule_mask;
        logic                  named_type_used;
    } dstr_out_t;

    // Accumulated specifier state of one declaration
    typedef struct packed {
        logic [1:0] data_cnt;
        logic [1:0] sgn_cnt;
        logic [1:0] uns_cnt;
        logic [1:0] long_cnt;
        logic [1:0] short_cnt;
        logic [1:0] cplx_cnt;
        logic [4:0] core_type;
        logic       named_seen;
    } dstr_state_t;

    localparam dstr_state_t STATE_INIT = '{
        data_cnt:   2'd0,
        sgn_cnt:    2'd0,
        uns_cnt:    2'd0,
        long_cnt:   2'd0,
        short_cnt:  2'd0,
        cplx_cnt:   2'd0,
        core_type:  T_INT,
        named_seen: 1'b0
    };

    // Saturating 2-bit increment
    function automatic logic [1:0] bump(input logic [1:0] c);
        return (c == 2'd3) ? 2'd3 : c + 2'd1;
    endfunction

endpackage

`default_nettype wire

// File: design/dstr_accum.sv
// ----------------------------------------------------------------------------
// dstr_accum
// Specifier state of the open declaration. Folds the current token into the
// counters and base type, and returns to the initial state after the last
// token of a declaration.
// ----------------------------------------------------------------------------
`default_nettype none

module dstr_accum (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  fire,
    input  wire dstr_pkg::dstr_in_t    tok,
    output dstr_pkg::dstr_state_t      upd
);
    import dstr_pkg::*;

    dstr_state_t state_reg;
    dstr_state_t state_next;

    // Fold the current token into the state
    always_comb
    begin
        upd = state_reg;
        unique case (dstr_spec_t'(tok.spec_code))
            SPEC_VOID:
            begin
                upd.data_cnt  = bump(state_reg.data_cnt);
                upd.core_type = T_VOID;
            end
            SPEC_CHAR:
            begin
                upd.data_cnt  = bump(state_reg.data_cnt);
                upd.core_type = T_CHAR;
            end
            SPEC_INT:
            begin
                upd.data_cnt  = bump(state_reg.data_cnt);
                upd.core_type = T_INT;
            end
            SPEC_DOUBLE:
            begin
                upd.data_cnt  = bump(state_reg.data_cnt);
                upd.core_type = T_DOUBLE;
            end
            SPEC_FLOAT:
            begin
                upd.data_cnt  = bump(state_reg.data_cnt);
                upd.core_type = T_FLOAT;
            end
            SPEC_TYPEDEF:
            begin
                upd.data_cnt   = bump(state_reg.data_cnt);
                upd.core_type  = (tok.named_type_code > T_UNRESOLVED) ?
                                 T_UNRESOLVED : tok.named_type_code;
                upd.named_seen = 1'b1;
            end
            SPEC_COMPLEX:  upd.cplx_cnt  = bump(state_reg.cplx_cnt);
            SPEC_SHORT:    upd.short_cnt = bump(state_reg.short_cnt);
            SPEC_LONG:     upd.long_cnt  = bump(state_reg.long_cnt);
            SPEC_SIGNED:   upd.sgn_cnt   = bump(state_reg.sgn_cnt);
            SPEC_UNSIGNED: upd.uns_cnt   = bump(state_reg.uns_cnt);
            SPEC_ENUM, SPEC_STRUCT, SPEC_UNION:
            begin
                upd.data_cnt  = bump(state_reg.data_cnt);
                upd.core_type = T_PENDING;
            end
            default:
            begin
                upd = state_reg;
            end
        endcase
    end

    // Advance on each consumed token, restart after the last one
    always_comb
    begin
        state_next = state_reg;
        if (fire)
        begin
            state_next = tok.last_token ? STATE_INIT : upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: design/dstr_resolve.sv
// ----------------------------------------------------------------------------
// dstr_resolve
// Rule check and type adjustment. Evaluates the fifteen specifier rules on
// the final state and, when none fails, applies signedness, complex and
// length modifiers to the base type.
// ----------------------------------------------------------------------------
`default_nettype none

module dstr_resolve (
    input  wire dstr_pkg::dstr_state_t st,
    output dstr_pkg::dstr_out_t        res
);
    import dstr_pkg::*;

    logic                  sg;
    logic                  us;
    logic                  lg;
    logic                  sh;
    logic                  cx;
    logic [4:0]            bt;
    logic [RULE_COUNT-1:0] mask;
    logic [4:0]            t_sign;
    logic [4:0]            t_cplx;
    logic [4:0]            t_len;

    assign sg = (st.sgn_cnt != 2'd0);
    assign us = (st.uns_cnt != 2'd0);
    assign lg = (st.long_cnt != 2'd0);
    assign sh = (st.short_cnt != 2'd0);
    assign cx = (st.cplx_cnt != 2'd0);
    assign bt = st.core_type;

    // Check specifier rules
    always_comb
    begin
        mask     = '0;
        mask[0]  = cx && (bt != T_FLOAT) && (bt != T_DOUBLE);
        mask[1]  = (st.data_cnt > 2'd1);
        mask[2]  = (st.sgn_cnt > 2'd1);
        mask[3]  = (st.uns_cnt > 2'd1);
        mask[4]  = (st.long_cnt > 2'd2);
        mask[5]  = (st.short_cnt > 2'd1);
        mask[6]  = (st.cplx_cnt > 2'd1);
        mask[7]  = sg && us;
        mask[8]  = lg && sh;
        mask[9]  = (sg || us) && (bt == T_DOUBLE);
        mask[10] = (sg || us) && (bt == T_FLOAT);
        mask[11] = (lg || sh) && (bt == T_FLOAT);
        mask[12] = (lg || sh) && (bt == T_CHAR);
        mask[13] = sh && (bt == T_DOUBLE);
        mask[14] = (st.long_cnt > 2'd1) && (bt == T_DOUBLE);
    end

    // Apply signedness
    always_comb
    begin
        t_sign = bt;
        if (sg)
        begin
            priority if (bt == T_CHAR || bt == T_UCHAR) t_sign = T_SCHAR;
            else if (bt == T_UINT)   t_sign = T_INT;
            else if (bt == T_USHORT) t_sign = T_SHORT;
            else if (bt == T_ULONG)  t_sign = T_LONG;
            else if (bt == T_ULLONG) t_sign = T_LLONG;
            else                     t_sign = bt;
        end
        else if (us)
        begin
            priority if (bt == T_CHAR || bt == T_SCHAR) t_sign = T_UCHAR;
            else if (bt == T_INT)   t_sign = T_UINT;
            else if (bt == T_SHORT) t_sign = T_USHORT;
            else if (bt == T_LONG)  t_sign = T_ULONG;
            else if (bt == T_LLONG) t_sign = T_ULLONG;
            else                    t_sign = bt;
        end
    end

    // Apply complex
    always_comb
    begin
        t_cplx = t_sign;
        if (cx)
        begin
            if (t_sign == T_FLOAT)
            begin
                t_cplx = T_FCOMPLEX;
            end
            else if (t_sign == T_DOUBLE)
            begin
                t_cplx = T_DCOMPLEX;
            end
        end
    end

    // Apply long, long long or short
    always_comb
    begin
        t_len = t_cplx;
        if (st.long_cnt == 2'd1)
        begin
            priority if (t_cplx == T_INT)      t_len = T_LONG;
            else if (t_cplx == T_UINT)     t_len = T_ULONG;
            else if (t_cplx == T_DOUBLE)   t_len = T_LDOUBLE;
            else if (t_cplx == T_DCOMPLEX) t_len = T_LDCOMPLEX;
            else                           t_len = t_cplx;
        end
        else if (st.long_cnt == 2'd2)
        begin
            if (t_cplx == T_INT)       t_len = T_LLONG;
            else if (t_cplx == T_UINT) t_len = T_ULLONG;
        end
        else if (sh)
        begin
            if (t_cplx == T_INT)       t_len = T_SHORT;
            else if (t_cplx == T_UINT) t_len = T_USHORT;
        end
    end

    // Form the result word
    always_comb
    begin
        res.rule_mask = mask;
        if (mask == '0)
        begin
            res.result_type     = t_len;
            res.named_type_used = st.named_seen;
        end
        else
        begin
            res.result_type     = T_ERROR;
            res.named_type_used = 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: design/decl_specifier_type_resolver.sv
// After its last token is accepted, a result word is held back only while an
// earlier result word still waits to be taken, then enters the result register.
// Throughput: one token per cycle, except while a last token waits for room;
// input and result registers let a new token in while a result waits to be taken.
// Reset: rst_n clears the valid flags and returns the specifier state to
// "no specifiers, base type int".
// ----------------------------------------------------------------------------
// decl_specifier_type_resolver
// Resolves the specifier tokens of one C declaration to a type code, a rule
// violation mask and a typedef-used flag, one result per declaration.
// ----------------------------------------------------------------------------
`default_nettype none

module decl_specifier_type_resolver (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire dstr_pkg::dstr_in_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output dstr_pkg::dstr_out_t      out_data
);
    import dstr_pkg::*;

    dstr_in_t    tok_reg;
    logic        tok_valid_reg;
    logic        tok_valid_next;
    dstr_out_t   res_reg;
    logic        res_valid_reg;
    logic        res_valid_next;
    logic        out_free;
    logic        fire;
    dstr_state_t upd;
    dstr_out_t   res;

    // Consume the held token unless it would produce a result with no room
    assign out_free = !res_valid_reg || out_ready;
    assign fire     = tok_valid_reg && (!tok_reg.last_token || out_free);
    assign in_ready = !tok_valid_reg || fire;

    dstr_accum u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .tok   (tok_reg),
        .upd   (upd)
    );

    dstr_resolve u_resolve (
        .st  (upd),
        .res (res)
    );

    // Valid flags for token and result stages
    always_comb
    begin
        tok_valid_next = tok_valid_reg;
        if (in_valid && in_ready)
        begin
            tok_valid_next = 1'b1;
        end
        else if (fire)
        begin
            tok_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (fire && tok_reg.last_token)
        begin
            res_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Hold payloads
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            tok_reg <= in_data;
        end
        if (fire && tok_reg.last_token)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

endmodule

`default_nettype wire
